// ===== hw/rtl/kmc_pkg.sv =====
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types, training table and control structs of the k-nearest-neighbor
// material classifier.
// ----------------------------------------------------------------------------
package kmc_pkg;

   localparam int TABLE_ROWS = 10;
   localparam int NUM_LABELS = 5;
   localparam int NUM_FEATS  = 5;
   localparam int ROW_W      = 4;
   localparam int FEAT_SEL_W = 3;
   localparam int FEAT_W     = 28;
   localparam int SQ_W       = 56;
   localparam int DIST_W     = 59;
   localparam int CLASS_W    = 3;
   localparam int TAB_W      = 9;

   localparam logic [FEAT_SEL_W-1:0] FEAT_WEIGHT   = 3'd0;
   localparam logic [FEAT_SEL_W-1:0] FEAT_COND     = 3'd1;
   localparam logic [FEAT_SEL_W-1:0] FEAT_MAGNETIC = 3'd2;
   localparam logic [FEAT_SEL_W-1:0] FEAT_IR       = 3'd3;
   localparam logic [FEAT_SEL_W-1:0] FEAT_RAD      = 3'd4;

   localparam logic [CLASS_W-1:0] LABEL_EWASTE     = 3'd0;
   localparam logic [CLASS_W-1:0] LABEL_FERROUS    = 3'd1;
   localparam logic [CLASS_W-1:0] LABEL_HAZARDOUS  = 3'd2;
   localparam logic [CLASS_W-1:0] LABEL_NONFERROUS = 3'd3;
   localparam logic [CLASS_W-1:0] LABEL_RECYCLABLE = 3'd4;

   typedef logic [FEAT_W-1:0]     feat_type;
   typedef logic [SQ_W-1:0]       sq_type;
   typedef logic [DIST_W-1:0]     dist_type;
   typedef logic [CLASS_W-1:0]    label_type;
   typedef logic [ROW_W-1:0]      row_idx_type;
   typedef logic [FEAT_SEL_W-1:0] feat_sel_type;

   typedef struct packed {
      logic [TAB_W-1:0] w;
      logic [TAB_W-1:0] c;
      logic [TAB_W-1:0] m;
      logic [TAB_W-1:0] ir;
      logic [TAB_W-1:0] r;
      label_type        label;
   } row_type;

   typedef struct packed {
      logic         diff_en;
      logic         mul_en;
      logic         acc_en;
      logic         acc_first;
      feat_sel_type feat_sel;
   } dist_ctl_type;

   typedef struct packed {
      logic      clear;
      logic      ins_en;
      logic      vote_en;
      logic      vote_first;
      label_type label_sel;
   } rank_ctl_type;

   typedef struct packed {
      logic      ins_done;
      label_type best;
   } rank_sts_type;

   function automatic row_type train_row(input row_idx_type idx);
      row_type t;
      unique case (idx)
         4'd0:    t = '{9'd300, 9'd10, 9'd1, 9'd50, 9'd0,  LABEL_FERROUS};
         4'd1:    t = '{9'd450, 9'd12, 9'd1, 9'd55, 9'd0,  LABEL_FERROUS};
         4'd2:    t = '{9'd80,  9'd40, 9'd0, 9'd85, 9'd0,  LABEL_NONFERROUS};
         4'd3:    t = '{9'd120, 9'd38, 9'd0, 9'd90, 9'd0,  LABEL_NONFERROUS};
         4'd4:    t = '{9'd100, 9'd55, 9'd0, 9'd95, 9'd0,  LABEL_RECYCLABLE};
         4'd5:    t = '{9'd150, 9'd60, 9'd0, 9'd97, 9'd0,  LABEL_RECYCLABLE};
         4'd6:    t = '{9'd200, 9'd15, 9'd0, 9'd30, 9'd50, LABEL_EWASTE};
         4'd7:    t = '{9'd250, 9'd20, 9'd0, 9'd35, 9'd70, LABEL_EWASTE};
         4'd8:    t = '{9'd50,  9'd5,  9'd0, 9'd20, 9'd90, LABEL_HAZARDOUS};
         4'd9:    t = '{9'd60,  9'd7,  9'd0, 9'd25, 9'd85, LABEL_HAZARDOUS};
         default: t = '{9'd0,   9'd0,  9'd0, 9'd0,  9'd0,  LABEL_HAZARDOUS};
      endcase
      return t;
   endfunction

endpackage

// ===== hw/rtl/kmc_dist_unit.sv =====
// ----------------------------------------------------------------------------
// kmc_dist_unit
// Shared difference, square and accumulate datapath: one feature per cycle
// while enabled; three overlapped stages; squared distance of a row in acc.
// ----------------------------------------------------------------------------
module kmc_dist_unit
   import kmc_pkg::*;
(
   input  logic         clock,
   input  dist_ctl_type ctl,
   input  row_idx_type  row,
   input  feat_type     feats [NUM_FEATS],
   output dist_type     row_dist
);

   feat_type diff_ff;
   feat_type diff_in;
   sq_type   prod_ff;
   dist_type acc_ff;
   dist_type acc_in;
   feat_type sample;
   feat_type ref_val;
   row_type  t;

   function automatic feat_type scale_tab(input logic [TAB_W-1:0] v);
      return {{(FEAT_W-TAB_W-8){1'b0}}, v, 8'd0};
   endfunction

   always_comb begin
      t = train_row(row);
      unique case (ctl.feat_sel)
         FEAT_WEIGHT: begin
            sample  = feats[0];
            ref_val = scale_tab(t.w);
         end
         FEAT_COND: begin
            sample  = feats[1];
            ref_val = scale_tab(t.c);
         end
         FEAT_MAGNETIC: begin
            sample  = feats[2];
            ref_val = scale_tab(t.m);
         end
         FEAT_IR: begin
            sample  = feats[3];
            ref_val = scale_tab(t.ir);
         end
         FEAT_RAD: begin
            sample  = feats[4];
            ref_val = scale_tab(t.r);
         end
         default: begin
            sample  = '0;
            ref_val = '0;
         end
      endcase
      diff_in = (sample >= ref_val) ? (sample - ref_val) : (ref_val - sample);
      acc_in  = ctl.acc_first ? DIST_W'(prod_ff) : (acc_ff + DIST_W'(prod_ff));
   end

   always_ff @(posedge clock) begin
      if (ctl.diff_en) begin
         diff_ff <= diff_in;
      end
      if (ctl.mul_en) begin
         prod_ff <= SQ_W'(diff_ff) * SQ_W'(diff_ff);
      end
      if (ctl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   assign row_dist = acc_ff;

endmodule

// ===== hw/rtl/kmc_rank_vote.sv =====
// ----------------------------------------------------------------------------
// kmc_rank_vote
// Sorted list of the nearest rows, filled by one-slot-per-cycle insertion,
// then a majority vote that scans the labels one per cycle.
// ----------------------------------------------------------------------------
module kmc_rank_vote
   import kmc_pkg::*;
#(
   parameter int K = 3
) (
   input  logic         clock,
   input  logic         reset,
   input  rank_ctl_type ctl,
   input  dist_type     cand_dist,
   input  label_type    cand_label,
   output rank_sts_type sts
);

   localparam int SLOT_IW = (K > 1) ? $clog2(K) : 1;
   localparam int PTR_W   = $clog2(K + 1);
   localparam int VW      = $clog2(K + 1);

   dist_type         slot_dist_ff [K];
   label_type        slot_lab_ff  [K];
   logic [PTR_W-1:0] ptr_ff;
   logic [PTR_W-1:0] ptr_in;
   logic [VW-1:0]    top_ff;
   logic [VW-1:0]    top_in;
   label_type        best_ff;
   label_type        best_in;

   logic [SLOT_IW-1:0] prev_idx;
   logic [SLOT_IW-1:0] wr_idx;
   logic               wr_en;
   dist_type           wr_dist;
   label_type          wr_lab;
   logic               done;
   logic [VW-1:0]      cnt;
   logic [VW-1:0]      top_cur;
   label_type          best_cur;

   always_comb begin
      prev_idx = SLOT_IW'(ptr_ff - PTR_W'(1));
      wr_idx   = SLOT_IW'(ptr_ff);
      wr_en    = 1'b0;
      wr_dist  = cand_dist;
      wr_lab   = cand_label;
      done     = 1'b0;
      ptr_in   = ptr_ff;
      if (ctl.ins_en) begin
         priority if (ptr_ff == '0) begin
            wr_en  = 1'b1;
            wr_idx = '0;
            done   = 1'b1;
         end else if (slot_dist_ff[prev_idx] > cand_dist) begin
            wr_en   = (ptr_ff != PTR_W'(K));
            wr_dist = slot_dist_ff[prev_idx];
            wr_lab  = slot_lab_ff[prev_idx];
            ptr_in  = ptr_ff - PTR_W'(1);
         end else begin
            wr_en = (ptr_ff != PTR_W'(K));
            done  = 1'b1;
         end
      end
      if (done || ctl.clear) begin
         ptr_in = PTR_W'(K);
      end
   end

   always_comb begin
      cnt = '0;
      for (int i = 0; i < K; i++) begin
         cnt = cnt + VW'(slot_lab_ff[i] == ctl.label_sel);
      end
      top_cur  = ctl.vote_first ? '0 : top_ff;
      best_cur = ctl.vote_first ? LABEL_EWASTE : best_ff;
      if (cnt > top_cur) begin
         top_in  = cnt;
         best_in = ctl.label_sel;
      end else begin
         top_in  = top_cur;
         best_in = best_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= PTR_W'(K);
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         for (int i = 0; i < K; i++) begin
            slot_dist_ff[i] <= '1;
         end
      end else if (wr_en) begin
         slot_dist_ff[wr_idx] <= wr_dist;
         slot_lab_ff[wr_idx]  <= wr_lab;
      end
      if (ctl.vote_en) begin
         top_ff  <= top_in;
         best_ff <= best_in;
      end
   end

   assign sts.ins_done = done;
   assign sts.best     = best_in;

endmodule

// ===== hw/rtl/knn_material_classifier_core.sv =====
// ----------------------------------------------------------------------------
// knn_material_classifier_core
// Three-nearest-neighbor material classifier over a constant table of
// labelled training rows, built around one shared square-and-add unit.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each training row
// goes through the shared difference/multiply/accumulate unit and is then
// inserted into the sorted neighbor list, after which the vote scans the
// 5 labels one per cycle. The first rows always shift deep into the empty
// list, and the next item can be taken as soon as busy drops. The result
// shows on rsp_valid for one cycle as busy drops; there is no way to stall
// it, so the receiver must take it in that cycle.
module knn_material_classifier_core
   import kmc_pkg::*;
#(
   parameter int NUM_SAMPLES = 10,
   parameter int NEIGHBOURS  = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [27:0]           req_weight,
   input  logic [27:0]           req_conductivity,
   input  logic                  req_magnetic,
   input  logic [14:0]           req_ir_purity,
   input  logic [27:0]           req_radiation,
   output logic                  rsp_valid,
   output logic [CLASS_W-1:0]    rsp_material_class
);

   localparam int ROWS = (NUM_SAMPLES < TABLE_ROWS) ? NUM_SAMPLES : TABLE_ROWS;
   localparam int K    = (NEIGHBOURS < ROWS) ? NEIGHBOURS : ROWS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIST = 2'd1;
   localparam logic [1:0] ST_INS  = 2'd2;
   localparam logic [1:0] ST_VOTE = 2'd3;

   localparam logic [2:0]  STEP_LAST = 3'd6;
   localparam row_idx_type ROW_LAST  = ROW_W'(ROWS - 1);
   localparam label_type   LAB_LAST  = CLASS_W'(NUM_LABELS - 1);

   logic [1:0]  state_ff;
   logic [1:0]  state_in;
   row_idx_type row_ff;
   row_idx_type row_in;
   logic [2:0]  step_ff;
   logic [2:0]  step_in;
   label_type   lab_ff;
   label_type   lab_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   label_type   rsp_class_ff;
   feat_type    feat_ff [NUM_FEATS];

   logic         accept;
   dist_ctl_type dctl;
   rank_ctl_type rctl;
   rank_sts_type rsts;
   dist_type     row_dist;
   row_type      cur_row;

   assign accept  = start && (state_ff == ST_IDLE);
   assign cur_row = train_row(row_ff);

   always_comb begin
      dctl.diff_en   = (state_ff == ST_DIST) && (step_ff <= 3'd4);
      dctl.mul_en    = (state_ff == ST_DIST) && (step_ff >= 3'd1) && (step_ff <= 3'd5);
      dctl.acc_en    = (state_ff == ST_DIST) && (step_ff >= 3'd2);
      dctl.acc_first = (step_ff == 3'd2);
      dctl.feat_sel  = feat_sel_type'(step_ff);

      rctl.clear      = accept;
      rctl.ins_en     = (state_ff == ST_INS);
      rctl.vote_en    = (state_ff == ST_VOTE);
      rctl.vote_first = (lab_ff == LABEL_EWASTE);
      rctl.label_sel  = lab_ff;
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      step_in      = step_ff;
      lab_in       = lab_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DIST;
               row_in   = '0;
               step_in  = '0;
            end
         end
         ST_DIST: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_INS;
               step_in  = '0;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_INS: begin
            if (rsts.ins_done) begin
               if (row_ff == ROW_LAST) begin
                  state_in = ST_VOTE;
                  lab_in   = LABEL_EWASTE;
               end else begin
                  state_in = ST_DIST;
                  row_in   = row_ff + ROW_W'(1);
               end
            end
         end
         ST_VOTE: begin
            if (lab_ff == LAB_LAST) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end else begin
               lab_in = lab_ff + CLASS_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         step_ff      <= '0;
         lab_ff       <= LABEL_EWASTE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         step_ff      <= step_in;
         lab_ff       <= lab_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         feat_ff[0] <= req_weight;
         feat_ff[1] <= req_conductivity;
         feat_ff[2] <= {{(FEAT_W-9){1'b0}}, req_magnetic, 8'd0};
         feat_ff[3] <= {{(FEAT_W-15){1'b0}}, req_ir_purity};
         feat_ff[4] <= req_radiation;
      end
      if (rsp_valid_in) begin
         rsp_class_ff <= rsts.best;
      end
   end

   kmc_dist_unit u_dist (
      .clock    (clock),
      .ctl      (dctl),
      .row      (row_ff),
      .feats    (feat_ff),
      .row_dist (row_dist)
   );

   kmc_rank_vote #(
      .K (K)
   ) u_rank (
      .clock      (clock),
      .reset      (reset),
      .ctl        (rctl),
      .cand_dist  (row_dist),
      .cand_label (cur_row.label),
      .sts        (rsts)
   );

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_material_class = rsp_class_ff;

endmodule

// ===== tb/kmc_check_pkg.sv =====
// ----------------------------------------------------------------------------
// kmc_check_pkg
// Training table, nearest-neighbor label predictor and result scoreboard for
// the material classifier testbench.
// ----------------------------------------------------------------------------
package kmc_check_pkg;

   import kmc_pkg::*;

   localparam int KNN_K = 3;

   typedef struct {
      int unsigned w;
      int unsigned c;
      int unsigned m;
      int unsigned ir;
      int unsigned r;
      label_type   label;
   } train_sample_type;

   function automatic train_sample_type train_entry(input int idx);
      train_sample_type t;
      case (idx)
         0:       t = '{300, 10, 1, 50, 0,  LABEL_FERROUS};
         1:       t = '{450, 12, 1, 55, 0,  LABEL_FERROUS};
         2:       t = '{80,  40, 0, 85, 0,  LABEL_NONFERROUS};
         3:       t = '{120, 38, 0, 90, 0,  LABEL_NONFERROUS};
         4:       t = '{100, 55, 0, 95, 0,  LABEL_RECYCLABLE};
         5:       t = '{150, 60, 0, 97, 0,  LABEL_RECYCLABLE};
         6:       t = '{200, 15, 0, 30, 50, LABEL_EWASTE};
         7:       t = '{250, 20, 0, 35, 70, LABEL_EWASTE};
         8:       t = '{50,  5,  0, 20, 90, LABEL_HAZARDOUS};
         9:       t = '{60,  7,  0, 25, 85, LABEL_HAZARDOUS};
         default: t = '{0,   0,  0, 0,  0,  LABEL_HAZARDOUS};
      endcase
      return t;
   endfunction

   function automatic bit [63:0] sq_gap(input bit [63:0] a, input bit [63:0] b);
      bit [63:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return d * d;
   endfunction

   function automatic label_type nearest_majority(input feat_type w, input feat_type c,
                                                  input logic m, input logic [14:0] ir,
                                                  input feat_type r);
      bit [63:0]        row_dist [TABLE_ROWS];
      bit               taken [TABLE_ROWS];
      int unsigned      votes [NUM_LABELS];
      train_sample_type t;
      int               pick;
      int unsigned      top;
      label_type        best;
      for (int i = 0; i < TABLE_ROWS; i++) begin
         t = train_entry(i);
         row_dist[i] = sq_gap(64'(t.w) << 8, 64'(w)) + sq_gap(64'(t.c) << 8, 64'(c))
                     + sq_gap(64'(t.m) << 8, 64'(m) << 8) + sq_gap(64'(t.ir) << 8, 64'(ir))
                     + sq_gap(64'(t.r) << 8, 64'(r));
         taken[i] = 1'b0;
      end
      for (int l = 0; l < NUM_LABELS; l++) begin
         votes[l] = 0;
      end
      // strict less-than keeps table order on equal distance
      for (int j = 0; j < KNN_K; j++) begin
         pick = -1;
         for (int i = 0; i < TABLE_ROWS; i++) begin
            if (!taken[i] && (pick < 0 || row_dist[i] < row_dist[pick])) begin
               pick = i;
            end
         end
         taken[pick] = 1'b1;
         t = train_entry(pick);
         votes[t.label]++;
      end
      best = LABEL_EWASTE;
      top  = 0;
      for (int l = 0; l < NUM_LABELS; l++) begin
         if (votes[l] > top) begin
            top  = votes[l];
            best = label_type'(l);
         end
      end
      return best;
   endfunction

   class label_scoreboard;
      label_type expected_labels[$];
      int        checked    = 0;
      int        mismatches = 0;

      function void note_item(input feat_type w, input feat_type c, input logic m,
                              input logic [14:0] ir, input feat_type r);
         expected_labels.push_back(nearest_majority(w, c, m, ir, r));
      endfunction

      function void check_label(input label_type got, input longint unsigned stamp);
         label_type want;
         if (expected_labels.size() == 0) begin
            $display("%0t: material_class expected none, actual %0d", stamp, got);
            mismatches++;
            return;
         end
         want = expected_labels.pop_front();
         checked++;
         if (got !== want) begin
            $display("%0t: material_class expected %0d, actual %0d", stamp, want, got);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_labels.size();
      endfunction
   endclass

endpackage

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for knn_material_classifier_core: directed extremes,
// training rows and tie cases, then random near-row, blended, nominal and
// full-width items with start gaps, each class checked against a predictor.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kmc_pkg::*;
   import kmc_check_pkg::*;

   localparam int       RANDOM_ITEMS = 930;
   localparam int       CALM_ITEMS   = 150;
   localparam int       STALL_LIMIT  = 2000;
   localparam int       DRAIN_CYCLES = 200;
   localparam feat_type FEAT_TOP     = '1;
   localparam logic [14:0] IR_TOP    = '1;

   typedef enum int {HOLD_NONE, HOLD_BURST, HOLD_AFTER_DONE, HOLD_DRAIN} hold_kind_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   feat_type          req_weight       = '0;
   feat_type          req_conductivity = '0;
   logic              req_magnetic     = 1'b0;
   logic [14:0]       req_ir_purity    = '0;
   feat_type          req_radiation    = '0;
   logic              rsp_valid;
   logic [CLASS_W-1:0] rsp_material_class;

   label_scoreboard sb = new;
   int              items_sent = 0;
   int              directed_items = 0;

   knn_material_classifier_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_weight         (req_weight),
      .req_conductivity   (req_conductivity),
      .req_magnetic       (req_magnetic),
      .req_ir_purity      (req_ir_purity),
      .req_radiation      (req_radiation),
      .rsp_valid          (rsp_valid),
      .rsp_material_class (rsp_material_class)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_label(rsp_material_class, $time);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || rsp_valid || (start && !busy)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: nothing accepted for %0d cycles", $time, STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   task automatic send_item(input feat_type w, input feat_type c, input logic m,
                            input logic [14:0] ir, input feat_type r);
      start            <= 1'b1;
      req_weight       <= w;
      req_conductivity <= c;
      req_magnetic     <= m;
      req_ir_purity    <= ir;
      req_radiation    <= r;
      do @(posedge clock); while (busy);
      sb.note_item(w, c, m, ir, r);
      items_sent++;
   endtask

   task automatic hold_off(input hold_kind_type kind);
      int gap;
      gap = $urandom_range(8, 1);
      start <= 1'b0;
      case (kind)
         HOLD_AFTER_DONE: begin
            do @(posedge clock); while (busy);
         end
         HOLD_DRAIN: begin
            while (sb.pending() != 0) @(posedge clock);
         end
         default: ;
      endcase
      repeat (gap) @(posedge clock);
   endtask

   function automatic feat_type jitter(input int unsigned base, input int unsigned span,
                                       input feat_type top);
      longint v;
      v = longint'(base) + longint'($urandom_range(2 * span)) - longint'(span);
      if (v < 0) v = 0;
      if (v > longint'(top)) v = longint'(top);
      return feat_type'(v);
   endfunction

   function automatic void draw_features(output feat_type w, output feat_type c,
                                         output logic m, output logic [14:0] ir,
                                         output feat_type r);
      int unsigned      kind;
      int unsigned      span;
      int unsigned      t;
      train_sample_type a;
      train_sample_type b;
      kind = $urandom_range(99);
      a = train_entry($urandom_range(TABLE_ROWS - 1));
      b = train_entry($urandom_range(TABLE_ROWS - 1));
      if (kind < 50) begin
         case ($urandom_range(2))
            0:       span = 255;
            1:       span = 20 * 256;
            default: span = 100 * 256;
         endcase
         w  = jitter(a.w * 256, span, FEAT_TOP);
         c  = jitter(a.c * 256, span, FEAT_TOP);
         m  = ($urandom_range(9) < 8) ? (a.m != 0) : (a.m == 0);
         ir = 15'(jitter(a.ir * 256, span, feat_type'(IR_TOP)));
         r  = jitter(a.r * 256, span, FEAT_TOP);
      end else if (kind < 70) begin
         t = $urandom_range(256);
         if ($urandom_range(3) == 0) t = 128;
         w  = feat_type'(a.w * t + b.w * (256 - t));
         c  = feat_type'(a.c * t + b.c * (256 - t));
         m  = 1'($urandom_range(1));
         ir = 15'(a.ir * t + b.ir * (256 - t));
         r  = feat_type'(a.r * t + b.r * (256 - t));
      end else if (kind < 85) begin
         w  = feat_type'($urandom_range(600 * 256));
         c  = feat_type'($urandom_range(100 * 256));
         m  = 1'($urandom_range(1));
         ir = 15'($urandom_range(25600));
         r  = feat_type'($urandom_range(100 * 256));
      end else begin
         w  = feat_type'($urandom());
         c  = feat_type'($urandom());
         m  = 1'($urandom());
         ir = 15'($urandom());
         r  = feat_type'($urandom());
      end
   endfunction

   initial begin
      feat_type         w;
      feat_type         c;
      logic             m;
      logic [14:0]      ir;
      feat_type         r;
      train_sample_type e;
      int unsigned      idle_pct;
      hold_kind_type    kind;
      idle_pct = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_item('0, '0, 1'b0, '0, '0);
      send_item(FEAT_TOP, FEAT_TOP, 1'b1, IR_TOP, FEAT_TOP);
      send_item(FEAT_TOP, '0, 1'b0, '0, '0);
      send_item('0, FEAT_TOP, 1'b0, '0, '0);
      send_item('0, '0, 1'b1, IR_TOP, '0);
      send_item('0, '0, 1'b0, '0, FEAT_TOP);
      for (int i = 0; i < TABLE_ROWS; i++) begin
         e = train_entry(i);
         send_item(feat_type'(e.w * 256), feat_type'(e.c * 256), e.m != 0,
                   15'(e.ir * 256), feat_type'(e.r * 256));
      end
      send_item(28'd76800, 28'd2560, 1'b0, 15'd12800, 28'd0);
      send_item(28'd25600, 28'd14080, 1'b1, 15'd24320, 28'd0);
      // equal distance to two rows
      send_item(28'd96000, 28'd2816, 1'b1, 15'd13440, 28'd0);
      send_item(28'd14080, 28'd1536, 1'b0, 15'd5760, 28'd22400);
      // three nearest rows carry three different labels
      send_item(28'd0, 28'd30720, 1'b0, 15'd0, 28'd0);
      directed_items = items_sent;
      hold_off(HOLD_DRAIN);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         draw_features(w, c, m, ir, r);
         send_item(w, c, m, ir, r);
         if (n % 40 == 0) begin
            case ($urandom_range(2))
               0:       idle_pct = 0;
               1:       idle_pct = 25;
               default: idle_pct = 60;
            endcase
         end
         kind = HOLD_NONE;
         if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(99) < idle_pct) begin
            case ($urandom_range(9))
               0:       kind = HOLD_DRAIN;
               1, 2, 3: kind = HOLD_AFTER_DONE;
               default: kind = HOLD_BURST;
            endcase
         end
         if (kind != HOLD_NONE) hold_off(kind);
      end
      start <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items: %0d directed (field extremes, training rows, ties),",
               items_sent, directed_items);
      $display("the rest random near-row, blended, nominal and full-width; %0d checked.",
               sb.checked);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/kmc_pkg.sv
hw/rtl/kmc_dist_unit.sv
hw/rtl/kmc_rank_vote.sv
hw/rtl/knn_material_classifier_core.sv
tb/kmc_check_pkg.sv
tb/tb.sv
